// ----- sv/lurl_pkg.sv -----
// Shared types, constants and the symbol fold table for the longest unique run block.
`default_nettype none

package lurl_pkg;

  localparam int unsigned SYMBOL_W          = 8;
  localparam int unsigned SYMBOL_CODES      = 1 << SYMBOL_W;
  localparam int unsigned LONGEST_W         = 9;
  localparam int unsigned ALPHABET_SIZE_DEF = 256;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch the folded byte of an accepted beat
    logic close;   // post the best length, clear the window
    logic drop;    // remove the window's front byte
    logic append;  // add the latched byte at the window's tail
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;          // latched byte already sits in the window
    logic out_blocked;  // result register full and stalled
  } status_t;

  typedef logic [SYMBOL_W-1:0] fold_tab_t [SYMBOL_CODES];

  // Map every byte code to code mod size, built by a wrapping counter.
  function automatic fold_tab_t fold_table(input int unsigned size);
    fold_tab_t   tab;
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < SYMBOL_CODES; i++) begin
      tab[i] = SYMBOL_W'(r);
      if (r == size - 1) begin
        r = 0;
      end else begin
        r = r + 1;
      end
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lurl_ctrl.sv -----
// Controller state machine: sequences accept, front drops and append per byte.
`default_nettype none

module lurl_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_closing,
  output logic                   in_stall,
  input  wire lurl_pkg::status_t st,
  output lurl_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_DROP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE) || (in_closing && st.out_blocked);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_closing) begin
          cmd.close = 1'b1;
        end else if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.hit) begin
          state_nxt = S_DROP;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DROP: begin
        cmd.drop  = 1'b1;
        state_nxt = S_CHECK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/lurl_dp.sv -----
// Datapath: membership mask, window ring memory, pointers, best length and result register.
`default_nettype none

module lurl_dp #(
  parameter int unsigned ALPHABET_SIZE = lurl_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [lurl_pkg::SYMBOL_W-1:0] in_symbol,
  input  wire lurl_pkg::cmd_t                cmd,
  output lurl_pkg::status_t                  st,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lurl_pkg::LONGEST_W-1:0]     out_longest
);

  localparam int unsigned SYM_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(ALPHABET_SIZE + 1);
  localparam lurl_pkg::fold_tab_t FOLD = lurl_pkg::fold_table(ALPHABET_SIZE);

  logic [SYM_W-1:0]              sym_r;
  logic [ALPHABET_SIZE-1:0]      mask_r, mask_nxt;
  logic [SYM_W-1:0]              front_r, front_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              best_r, best_nxt;
  logic [SYM_W-1:0]              rdata_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [lurl_pkg::LONGEST_W-1:0] out_longest_r;
  logic [SYM_W-1:0]              ring_mem [ALPHABET_SIZE];

  logic [CNT_W:0]                tail_sum;
  logic [SYM_W-1:0]              tail;
  logic [CNT_W-1:0]              count_inc;

  // Tail = (front + count) mod size; the sum stays below twice the size.
  assign tail_sum = (CNT_W+1)'(front_r) + (CNT_W+1)'(count_r);
  assign tail     = (tail_sum >= (CNT_W+1)'(ALPHABET_SIZE)) ?
                    SYM_W'(tail_sum - (CNT_W+1)'(ALPHABET_SIZE)) : SYM_W'(tail_sum);
  assign count_inc = count_r + CNT_W'(1);

  assign st.hit         = mask_r[sym_r] && (count_r != '0);
  assign st.out_blocked = out_valid_r && out_stall;

  always_comb begin
    mask_nxt      = mask_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.close) begin
      mask_nxt      = '0;
      front_nxt     = '0;
      count_nxt     = '0;
      best_nxt      = '0;
      out_valid_nxt = 1'b1;
    end
    if (cmd.drop) begin
      mask_nxt[rdata_r] = 1'b0;
      front_nxt = (front_r == SYM_W'(ALPHABET_SIZE - 1)) ? '0 : front_r + SYM_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end
    if (cmd.append) begin
      mask_nxt[sym_r] = 1'b1;
      count_nxt       = count_inc;
      if (count_inc > best_r) begin
        best_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      front_r     <= '0;
      count_r     <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r <= FOLD[in_symbol][SYM_W-1:0];
    end
    if (cmd.close) begin
      out_longest_r <= lurl_pkg::LONGEST_W'(best_r);
    end
  end

  // Window ring: write at tail on append, read front every cycle.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      ring_mem[tail] <= sym_r;
    end
    rdata_r <= ring_mem[front_r];
  end

  assign out_valid   = out_valid_r;
  assign out_longest = out_longest_r;

endmodule

`default_nettype wire

// ----- sv/longest_unique_run_length.sv -----
// Top level of the longest unique run length block: controller plus datapath.
//
//   channel  ports                          handshake
//   input    in_symbol[7:0], in_closing     in_valid / in_stall
//   result   out_longest[8:0]               out_valid / out_stall
//
// A byte beat is accepted, then checked for membership and appended; each byte
// dropped from the window's front adds a drop step and another check, and each drop
// waits on one registered read of the ring memory. The input stalls until the
// byte is appended. Each byte is dropped at most once. A closing beat clears
// mask, pointers and best length at once.
// Reset is synchronous, active low, and leaves the block ready the next cycle.
// The result sits in an output register; only a closing beat waits while it is
// full and stalled, byte beats keep flowing.
`default_nettype none

module longest_unique_run_length #(
  parameter int unsigned ALPHABET_SIZE = lurl_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lurl_pkg::SYMBOL_W-1:0] in_symbol,
  input  wire logic                          in_closing,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lurl_pkg::LONGEST_W-1:0]     out_longest
);

  lurl_pkg::cmd_t    cmd;
  lurl_pkg::status_t st;

  // Sequence each beat: accept, check, drop until clear, append.
  lurl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_closing (in_closing),
    .in_stall   (in_stall),
    .st         (st),
    .cmd        (cmd)
  );

  // Hold the window state and the result register.
  lurl_dp #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_symbol   (in_symbol),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_longest (out_longest)
  );

endmodule

`default_nettype wire

// ----- sv/lurl_checker.sv -----
// Port-level checker for the longest unique run length block, bound to the top level.
`default_nettype none

module lurl_checker #(
  parameter int unsigned ALPHABET_SIZE = lurl_pkg::ALPHABET_SIZE_DEF
) (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [lurl_pkg::SYMBOL_W-1:0] in_symbol,
  input wire logic                          in_closing,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [lurl_pkg::LONGEST_W-1:0] out_longest
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_longest))
    else $error("stalled result changed or dropped");

  // A result never exceeds the alphabet size.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_longest <= lurl_pkg::LONGEST_W'(ALPHABET_SIZE))
    else $error("result above alphabet size");

  // A byte beat occupies the block for the following cycle.
  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_closing |=> in_stall)
    else $error("byte beat did not hold off the next beat");

  // An accepted closing beat posts its result next cycle.
  a_close_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_closing |=> out_valid)
    else $error("closing beat produced no result");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind longest_unique_run_length lurl_checker #(
  .ALPHABET_SIZE (ALPHABET_SIZE)
) u_lurl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_symbol   (in_symbol),
  .in_closing  (in_closing),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_longest (out_longest)
);

`default_nettype wire

// ----- sim/lurl_run_checker.sv -----
// Checker for the longest unique run block: predicts each closing beat's result and compares.
`timescale 1ns / 100ps

module lurl_run_checker #(
  parameter int unsigned ALPHABET_SIZE = lurl_pkg::ALPHABET_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic [lurl_pkg::SYMBOL_W-1:0]  in_symbol,
  input  wire logic                           in_closing,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic [lurl_pkg::LONGEST_W-1:0] out_longest,
  output int                                  fail_count,
  output int                                  outstanding
);

  // Predicted window state
  bit                             seen [lurl_pkg::SYMBOL_CODES];
  logic [lurl_pkg::SYMBOL_W-1:0]  ring [lurl_pkg::SYMBOL_CODES];
  logic [lurl_pkg::SYMBOL_W-1:0]  head;
  logic [lurl_pkg::LONGEST_W-1:0] run_len;
  logic [lurl_pkg::LONGEST_W-1:0] best_len;

  logic [lurl_pkg::LONGEST_W-1:0] longest_q [$];
  int                             fails = 0;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic clear_window();
    foreach (seen[i]) seen[i] = 1'b0;
    head     = '0;
    run_len  = '0;
    best_len = '0;
  endtask

  task automatic take_byte(input logic [lurl_pkg::SYMBOL_W-1:0] raw);
    int unsigned                   s;
    int unsigned                   tail;
    logic [lurl_pkg::SYMBOL_W-1:0] gone;
    s = int'(raw) % ALPHABET_SIZE;
    // drop from the front until the incoming value has left the window
    while (seen[s] && run_len > 0) begin
      gone       = ring[head];
      seen[gone] = 1'b0;
      head       = lurl_pkg::SYMBOL_W'((int'(head) + 1) % ALPHABET_SIZE);
      run_len    = run_len - 1'b1;
    end
    tail                               = (int'(head) + int'(run_len)) % ALPHABET_SIZE;
    ring[tail[lurl_pkg::SYMBOL_W-1:0]] = lurl_pkg::SYMBOL_W'(s);
    seen[s]                            = 1'b1;
    run_len                            = run_len + 1'b1;
    if (run_len > best_len) best_len = run_len;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_window();
      longest_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (longest_q.size() == 0) begin
          $error("longest: result %0d with no closing beat pending", out_longest);
          fails++;
        end else begin
          logic [lurl_pkg::LONGEST_W-1:0] want;
          want = longest_q.pop_front();
          if (out_longest !== want) begin
            $error("longest: expected %0d, got %0d", want, out_longest);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_closing) begin
          longest_q.push_back(best_len);
          clear_window();
        end else begin
          take_byte(in_symbol);
        end
      end
    end
    outstanding <= longest_q.size();
    fail_count  <= fails;
  end

endmodule

// ----- sim/tb_longest_unique_run_length.sv -----
// Testbench top for the longest unique run block: stimulus, receiver pattern and verdict.
`timescale 1ns / 100ps

module tb_longest_unique_run_length;

  localparam int unsigned ALPHABET   = lurl_pkg::ALPHABET_SIZE_DEF;
  localparam int          ITEM_GOAL  = 1250;
  localparam int          LONG_HOLD  = 400;   // receiver hold-off, in cycles
  localparam int          QUIET_MAX  = 4000;  // cycles with no beat before giving up
  localparam int          DRAIN_TAIL = 16;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_valid   = 1'b0;
  logic                           in_stall;
  logic [lurl_pkg::SYMBOL_W-1:0]  in_symbol  = '0;
  logic                           in_closing = 1'b0;
  logic                           out_valid;
  logic                           out_stall  = 1'b0;
  logic [lurl_pkg::LONGEST_W-1:0] out_longest;

  int fail_count;
  int outstanding;

  // Sender burst bookkeeping
  int burst_left = 0;
  int items_sent = 0;

  // Receiver hold-off request: bump hold_ask, the receiver notices the change
  int hold_ask  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int seg_left  = 0;
  int stall_pct = 0;

  int quiet_cycles = 0;

  always #5 clk = ~clk;

  longest_unique_run_length #(
    .ALPHABET_SIZE(ALPHABET)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_symbol  (in_symbol),
    .in_closing (in_closing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_longest(out_longest)
  );

  lurl_run_checker #(
    .ALPHABET_SIZE(ALPHABET)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_symbol  (in_symbol),
    .in_closing (in_closing),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_longest(out_longest),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // Offer one beat and hold it until accepted. Between bursts, drop valid for a
  // random gap; some bursts are long so there are stretches with no idling.
  task automatic offer(input logic [lurl_pkg::SYMBOL_W-1:0] sym, input logic closing);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(60, 150);
      end else begin
        burst_left = $urandom_range(1, 24);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_symbol  <= sym;
    in_closing <= closing;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Send one string of len bytes drawn from a span of codes at a random base,
  // then its closing beat with a random (ignored) symbol.
  task automatic send_text(input int len, input int span);
    int base;
    base = $urandom_range(0, 255);
    for (int i = 0; i < len; i++) begin
      offer(lurl_pkg::SYMBOL_W'((base + $urandom_range(0, span - 1)) % 256), 1'b0);
    end
    offer(lurl_pkg::SYMBOL_W'($urandom), 1'b1);
  endtask

  // Send every code once in shuffled order (longest reaches the maximum),
  // then a random tail, which when not empty forces the window ring to wrap.
  task automatic send_all_codes(input int tail_len);
    logic [lurl_pkg::SYMBOL_W-1:0] perm [lurl_pkg::SYMBOL_CODES];
    logic [lurl_pkg::SYMBOL_W-1:0] t;
    int                            j;
    foreach (perm[i]) perm[i] = lurl_pkg::SYMBOL_W'(i);
    for (int i = lurl_pkg::SYMBOL_CODES - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    foreach (perm[i]) offer(perm[i], 1'b0);
    for (int i = 0; i < tail_len; i++) offer(lurl_pkg::SYMBOL_W'($urandom), 1'b0);
    offer(lurl_pkg::SYMBOL_W'($urandom), 1'b1);
  endtask

  // Hold the sender until every predicted result has been taken
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Receiver: a stall pattern of its own, in segments of random density,
  // overridden by a long hold-off whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 200);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int  pick;
    int  extra_perms;
    bit  held;
    extra_perms = 0;
    held        = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part
    offer(8'd0, 1'b1);                       // empty string reports zero
    offer(8'd255, 1'b1);                     // closing ignores its symbol
    offer(8'd0, 1'b0);                       // byte zero is an ordinary byte
    offer(8'd0, 1'b1);
    offer(8'd0, 1'b0);                       // repeated zeros keep the run at one
    offer(8'd0, 1'b0);
    offer(8'd0, 1'b0);
    offer(8'd0, 1'b1);
    offer(8'd255, 1'b0);                     // extremes around a zero
    offer(8'd0, 1'b0);
    offer(8'd255, 1'b0);
    offer(8'd0, 1'b1);
    offer(8'd1, 1'b0);                       // repeat in mid window drops the front
    offer(8'd2, 1'b0);
    offer(8'd3, 1'b0);
    offer(8'd1, 1'b0);
    offer(8'd4, 1'b0);
    offer(8'd128, 1'b1);

    // Pause the sender until every directed result is back
    drain_results();

    // Full alphabet once, with a wrapping tail
    send_all_codes($urandom_range(40, 120));

    while (items_sent < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 2 && extra_perms < 1) begin
        send_all_codes($urandom_range(0, 80));
        extra_perms++;
      end else if (pick < 65) begin
        send_text($urandom_range(0, 16), $urandom_range(1, 24));
      end else if (pick < 90) begin
        send_text($urandom_range(17, 90), $urandom_range(1, 256));
      end else begin
        send_text($urandom_range(0, 12), 256);
      end

      // Long receiver hold-off: keep offering short strings so the result
      // register fills and closing beats back up into the input
      if (!held && items_sent > 600) begin
        held     = 1'b1;
        hold_ask <= hold_ask + 1;
        for (int k = 0; k < 8; k++) begin
          send_text($urandom_range(0, 3), 256);
        end
      end
    end

    // Wait out every pending result, then let the block settle
    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
